@@ hdl/mlpd_pkg.sv @@
package mlpd_pkg;

   // Built size
   localparam int LEVELS = 8;
   localparam int DEPTH  = 16;

   localparam int LVL_IDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PTR_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int SUM_W     = CNT_W + 1;
   localparam int ADDR_W    = $clog2(LEVELS * DEPTH);
   localparam int DATA_W    = 32;
   localparam int CFG_W     = 5;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd8;

   // Operation codes
   localparam logic [2:0] FUNC_APPEND    = 3'd0;
   localparam logic [2:0] FUNC_INSERT    = 3'd1;
   localparam logic [2:0] FUNC_SERVE     = 3'd2;
   localparam logic [2:0] FUNC_POP_FRONT = 3'd3;
   localparam logic [2:0] FUNC_POP_BACK  = 3'd4;
   localparam logic [2:0] FUNC_PEEK_FRNT = 3'd5;
   localparam logic [2:0] FUNC_PEEK_BACK = 3'd6;
   localparam logic [2:0] FUNC_IS_EMPTY  = 3'd7;

   // Status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_BAD_LEVEL = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic exec;   // run the accepted request
      logic load;   // move pending result into output register
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

   // ring wrap of a sum known to be below 2*DEPTH
   function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] x);
      logic [SUM_W-1:0] y;
      begin
         y = (x >= SUM_W'(DEPTH)) ? (x - SUM_W'(DEPTH)) : x;
         wrap = y[PTR_W-1:0];
      end
   endfunction

endpackage

@@ hdl/mlpd_ram.sv @@
module mlpd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/mlpd_ctrl.sv @@
module mlpd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mlpd_pkg::stat_type stat,
   output mlpd_pkg::cmd_type  cmd
);
   import mlpd_pkg::*;

   typedef enum logic {S_IDLE, S_DONE} state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready;

   always_comb begin
      ready    = (state_ff == S_IDLE) || stat.out_free;
      cmd.exec = req_valid && ready;
      cmd.load = (state_ff == S_DONE) && stat.out_free;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.exec) state_in = S_DONE;
         end
         S_DONE: begin
            if (cmd.exec) state_in = S_DONE;
            else if (cmd.load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = ready;

endmodule

@@ hdl/mlpd_dp.sv @@
module mlpd_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  mlpd_pkg::cmd_type             cmd,
   output mlpd_pkg::stat_type            stat,
   input  logic                          csr_wr,
   input  logic [mlpd_pkg::CFG_W-1:0]    csr_levels_in_use,
   input  logic [2:0]                    req_func,
   input  logic [3:0]                    req_priority_req,
   input  logic signed [31:0]            req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_result_value,
   output logic [1:0]                    rsp_status,
   output logic [3:0]                    rsp_served_level,
   output logic                          rsp_level_empty
);
   import mlpd_pkg::*;

   logic [CFG_W-1:0] cfg_ff;
   logic [PTR_W-1:0] head_ff [LEVELS];
   logic [CNT_W-1:0] fill_ff [LEVELS];

   // result of the executed request, waiting on read data
   logic [1:0] pend_status_ff;
   logic [3:0] pend_level_ff;
   logic       pend_empty_ff;
   logic       pend_read_ff;

   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   logic [1:0]        rsp_status_ff;
   logic [3:0]        rsp_level_ff;
   logic              rsp_empty_ff;

   logic [CFG_W-1:0]     act;
   logic                 bad;
   logic [LVL_IDX_W-1:0] req_lv, pick_lv, sel_lv;
   logic                 pick_found;
   logic [PTR_W-1:0]     h, h_next, h_prev, pos_back, pos_tail;
   logic [CNT_W-1:0]     n;
   logic [SUM_W-1:0]     sum_hn;
   logic [1:0]           st_in;
   logic [3:0]           lvl_in;
   logic                 empty_in, read_in, wr_in;
   logic [PTR_W-1:0]     mem_pos;
   logic                 head_we, fill_we;
   logic [PTR_W-1:0]     head_in;
   logic [CNT_W-1:0]     fill_in;
   logic [ADDR_W-1:0]    mem_addr;
   logic [DATA_W-1:0]    rd_data;

   always_comb begin
      act     = (cfg_ff > CFG_W'(LEVELS)) ? CFG_W'(LEVELS) : cfg_ff;
      bad     = (req_priority_req == 4'd0) || ({1'b0, req_priority_req} > act);
      req_lv  = LVL_IDX_W'(req_priority_req - 4'd1);

      // highest non-empty admitted level
      pick_lv    = '0;
      pick_found = 1'b0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if ((fill_ff[i] != '0) && (CFG_W'(i) < act)) begin
            pick_lv    = LVL_IDX_W'(i);
            pick_found = 1'b1;
         end
      end

      sel_lv   = (req_func == FUNC_SERVE) ? pick_lv : req_lv;
      h        = head_ff[sel_lv];
      n        = fill_ff[sel_lv];
      sum_hn   = SUM_W'(h) + SUM_W'(n);
      pos_tail = wrap(sum_hn);
      pos_back = wrap(sum_hn - SUM_W'(1));
      h_next   = wrap(SUM_W'(h) + SUM_W'(1));
      h_prev   = (h == '0) ? PTR_W'(DEPTH - 1) : (h - PTR_W'(1));

      st_in    = ST_OK;
      lvl_in   = 4'd0;
      empty_in = 1'b0;
      read_in  = 1'b0;
      wr_in    = 1'b0;
      mem_pos  = h;
      head_we  = 1'b0;
      fill_we  = 1'b0;
      head_in  = h_next;
      fill_in  = n - CNT_W'(1);

      if (req_func == FUNC_SERVE) begin
         if (pick_found) begin
            lvl_in  = 4'(pick_lv) + 4'd1;
            read_in = 1'b1;
            head_we = 1'b1;
            fill_we = 1'b1;
         end else begin
            st_in = ST_EMPTY;
         end
      end else if (bad) begin
         st_in = ST_BAD_LEVEL;
      end else begin
         case (req_func)
            FUNC_APPEND, FUNC_INSERT: begin
               if (n >= CNT_W'(DEPTH)) begin
                  st_in = ST_FULL;
               end else begin
                  wr_in   = 1'b1;
                  fill_we = 1'b1;
                  fill_in = n + CNT_W'(1);
                  if (req_func == FUNC_APPEND) begin
                     mem_pos = pos_tail;
                  end else begin
                     mem_pos = h_prev;
                     head_in = h_prev;
                     head_we = 1'b1;
                  end
               end
            end
            FUNC_IS_EMPTY: begin
               empty_in = (n == '0);
            end
            default: begin
               if (n == '0) begin
                  st_in = ST_EMPTY;
               end else begin
                  lvl_in  = req_priority_req;
                  read_in = 1'b1;
                  if ((req_func == FUNC_POP_FRONT) || (req_func == FUNC_PEEK_FRNT)) begin
                     mem_pos = h;
                  end else begin
                     mem_pos = pos_back;
                  end
                  head_we = (req_func == FUNC_POP_FRONT);
                  fill_we = (req_func == FUNC_POP_FRONT) || (req_func == FUNC_POP_BACK);
               end
            end
         endcase
      end

      mem_addr = ADDR_W'(sel_lv) * ADDR_W'(DEPTH) + ADDR_W'(mem_pos);
   end

   mlpd_ram #(
      .WIDTH (DATA_W),
      .DEPTH (LEVELS * DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.exec && wr_in),
      .wr_addr (mem_addr),
      .wr_data (req_value),
      .rd_en   (cmd.exec && read_in),
      .rd_addr (mem_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         if (csr_wr) cfg_ff <= csr_levels_in_use;
         if (cmd.exec) begin
            if (head_we) head_ff[sel_lv] <= head_in;
            if (fill_we) fill_ff[sel_lv] <= fill_in;
         end
         if (cmd.load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         pend_status_ff <= st_in;
         pend_level_ff  <= lvl_in;
         pend_empty_ff  <= empty_in;
         pend_read_ff   <= read_in;
      end
      if (cmd.load) begin
         rsp_value_ff  <= pend_read_ff ? rd_data : '0;
         rsp_status_ff <= pend_status_ff;
         rsp_level_ff  <= pend_level_ff;
         rsp_empty_ff  <= pend_empty_ff;
      end
   end

   assign stat.out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_value  = rsp_value_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_served_level  = rsp_level_ff;
   assign rsp_level_empty   = rsp_empty_ff;

endmodule

@@ hdl/multi_level_priority_deque_unit.sv @@
// Multi-level priority deque: one bounded ring-buffer deque per priority level
// (8 levels of 16 entries, level 1 highest), all held in one entry RAM with
// registered read. Each request beat (func, priority_req, value) gives exactly
// one response beat: append/insert, serve-highest, pop/peek either end, or an
// is-empty test. A request first looks up the level's head and count,
// updates them and writes or reads the RAM; the registered read is then
// carried into the output register. The next request is taken while
// that result is loaded, so back-to-back requests sustain one beat per cycle
// as long as the response side keeps up. The response register lets a new
// request execute while an old response still waits; a stalled response
// holds off the request after that. csr_levels_in_use (reset 8, clipped to 8)
// limits the admitted levels; write it only while the block is idle. Values of
// never-written RAM entries are undefined.
module multi_level_priority_deque_unit (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [mlpd_pkg::CFG_W-1:0]   csr_levels_in_use,
   // request
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_func,
   input  logic [3:0]                   req_priority_req,
   input  logic signed [31:0]           req_value,
   // response
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [31:0]           rsp_result_value,
   output logic [1:0]                   rsp_status,
   output logic [3:0]                   rsp_served_level,
   output logic                         rsp_level_empty
);
   import mlpd_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // config register always accepts
   assign csr_ready = 1'b1;

   // sequencing: idle / result pending
   mlpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // level pointers, entry RAM, output register
   mlpd_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_wr            (csr_valid && csr_ready),
      .csr_levels_in_use (csr_levels_in_use),
      .req_func          (req_func),
      .req_priority_req  (req_priority_req),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status),
      .rsp_served_level  (rsp_served_level),
      .rsp_level_empty   (rsp_level_empty)
   );

endmodule
